@@ design/sp_pifo_stfq_packet_scheduler_defines.svh @@
// assertion macros for the packet scheduler
`ifndef SP_PIFO_STFQ_PACKET_SCHEDULER_DEFINES_SVH
`define SP_PIFO_STFQ_PACKET_SCHEDULER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SPS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SPS_ASSERT(label, clk, rst, prop, msg)
`define SPS_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ design/sps_pkg.sv @@
// shared constants and types for the packet scheduler
`timescale 1ns / 1ps
`default_nettype none
package sps_pkg;
   localparam int BandCountDefault   = 8;
   localparam int BandDepthDefault   = 1024;
   localparam int FlowEntriesDefault = 1024;
   localparam int TimeWidth          = 64;
   localparam int ReqDataWidth       = 64;
   localparam int RspDataWidth       = 104;
   localparam int CsrIndexWidth      = 2;
   localparam int CsrDataWidth       = 14;
   localparam logic [CsrIndexWidth-1:0] CsrTotalLimit = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrBandLimit  = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrHashMask   = 2'd2;
   typedef enum logic [2:0] {
      StEnqueued  = 3'd0,
      StDropTotal = 3'd1,
      StDropBand  = 3'd2,
      StDequeued  = 3'd3,
      StEmpty     = 3'd4
   } status_type;
   // true when a is strictly after b, wrap aware
   function automatic logic later(input logic [TimeWidth-1:0] a,
                                  input logic [TimeWidth-1:0] b);
      logic [TimeWidth-1:0] d;
      d = b - a;
      return d[TimeWidth-1];
   endfunction
endpackage
`default_nettype wire

@@ design/sp_pifo_stfq_packet_scheduler.sv @@
// strict-priority pifo scheduler with start-time fair queueing tags
`timescale 1ns / 1ps
`default_nettype none
`include "sp_pifo_stfq_packet_scheduler_defines.svh"
// Each request is an enqueue (kind 0) or a dequeue (kind 1) and gives one response.
// After reset the block clears all FLOW_ENTRIES entries (1024 by default) of the flow
// table, one entry a cycle, and holds req_tready low until that is done.
// After the request is accepted, the block reads the flow table memory, works out the
// start tag and the band, reads or writes the packet memory, takes the packet memory
// read data and then places the response (states S_READ, S_CALC, S_MEM, S_WAIT, S_OUT).
// One request is at work at a time, so a new request is taken only once the response
// has been accepted, after any stall on the response side; this follows from the
// read-modify-write loop through the flow and packet memories.
module sp_pifo_stfq_packet_scheduler #(
   parameter int BAND_COUNT   = sps_pkg::BandCountDefault,
   parameter int BAND_DEPTH   = sps_pkg::BandDepthDefault,
   parameter int FLOW_ENTRIES = sps_pkg::FlowEntriesDefault
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // flow_hash, packet_length, packet_tag
   input  wire logic [sps_pkg::ReqDataWidth-1:0] req_tdata,
   // kind
   input  wire logic                             req_tuser,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   // band, out_tag, out_length, start_tag, inversion, reordered
   output logic [sps_pkg::RspDataWidth-1:0]      rsp_tdata,
   // status
   output logic [2:0]                            rsp_tuser,
   input  wire logic                             csr_we,
   input  wire logic [sps_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [sps_pkg::CsrDataWidth-1:0] csr_wdata
);
   import sps_pkg::*;

   localparam int BW   = (BAND_COUNT > 1) ? $clog2(BAND_COUNT) : 1;
   localparam int DW   = $clog2(BAND_DEPTH);
   localparam int CW   = DW + 1;
   localparam int FW   = $clog2(FLOW_ENTRIES);
   localparam int SW   = BW + DW;
   localparam int TCW  = BW + DW + 1;
   localparam int SLOTS = BAND_COUNT * BAND_DEPTH;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_READ, S_CALC, S_MEM, S_WAIT, S_OUT
   } state_type;

   state_type state_ff;
   logic [13:0] total_limit_ff;
   logic [10:0] band_limit_ff;
   logic [9:0]  flow_mask_ff;

   // flow entry: valid bit above the tail time
   logic [TimeWidth:0] flow_mem [FLOW_ENTRIES];
   logic [TimeWidth:0] flow_rd_ff;
   logic [FW-1:0] clear_idx_ff;
   logic [31:0] tl_mem [SLOTS];
   logic [TimeWidth-1:0] st_mem [SLOTS];
   logic [31:0] tl_rd_ff;
   logic [TimeWidth-1:0] st_rd_ff;

   logic [TimeWidth-1:0] bound_ff [BAND_COUNT];
   logic [DW-1:0] head_ff [BAND_COUNT];
   logic [CW-1:0] count_ff [BAND_COUNT];
   logic [TCW-1:0] total_ff;
   logic [TimeWidth-1:0] gvt_ff;

   logic        kind_ff;
   logic [FW-1:0] fi_ff;
   logic [15:0] len_ff, tag_ff;
   logic        write_ff;
   logic [SW-1:0] slot_ff;
   logic [BW-1:0] band_ff;
   logic [2:0]  status_ff;
   logic [TimeWidth-1:0] vt_ff;
   logic        inv_ff;
   logic        reo_ff;
   logic [15:0] otag_ff, olen_ff;

   // start tag, enqueue band, band limit and dequeue band choice
   logic [TimeWidth-1:0] tail_c, vt_c, cost_c;
   logic [BW-1:0] eb_c;
   logic          placed_c, inv_c;
   logic [CW-1:0] lim_c;
   logic [BW-1:0] db_c;
   logic          found_c;

   always_comb begin
      tail_c = flow_rd_ff[TimeWidth] ? flow_rd_ff[TimeWidth-1:0] : gvt_ff;
      vt_c = later(gvt_ff, tail_c) ? gvt_ff : tail_c;
      eb_c = BW'(BAND_COUNT - 1);
      placed_c = 1'b0;
      for (int i = 0; i < BAND_COUNT - 1; i++) begin
         if (!placed_c && !later(bound_ff[i], vt_c)) begin
            eb_c = BW'(i);
            placed_c = 1'b1;
         end
      end
      inv_c = !placed_c && later(bound_ff[BAND_COUNT-1], vt_c);
      cost_c = bound_ff[BAND_COUNT-1] - vt_c;
      if (band_limit_ff == '0 || 32'(band_limit_ff) > BAND_DEPTH) begin
         lim_c = CW'(BAND_DEPTH);
      end else begin
         lim_c = CW'(band_limit_ff);
      end
      db_c = '0;
      found_c = 1'b0;
      for (int i = 0; i < BAND_COUNT; i++) begin
         if (count_ff[i] != '0) begin
            db_c = BW'(i);
            found_c = 1'b1;
         end
      end
   end

   logic [TimeWidth-1:0] pop_end_c;
   assign pop_end_c = st_rd_ff + TimeWidth'(tl_rd_ff[15:0]);

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {3'b000, reo_ff, inv_ff, vt_ff, olen_ff, otag_ff, 3'(band_ff)};

   // memories
   logic [FW-1:0] fi_in;
   assign fi_in = FW'(req_tdata[31:0] & 32'(flow_mask_ff));

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) flow_rd_ff <= flow_mem[fi_in];
      if (!reset && state_ff == S_CLEAR) begin
         flow_mem[clear_idx_ff] <= '0;
      end else if (state_ff == S_CALC && !kind_ff
                   && 32'(total_ff) < 32'(total_limit_ff)) begin
         flow_mem[fi_ff] <= {1'b1, vt_c + TimeWidth'(len_ff)};
      end
      if (state_ff == S_MEM && write_ff) begin
         tl_mem[slot_ff] <= {tag_ff, len_ff};
         st_mem[slot_ff] <= vt_ff;
      end
      tl_rd_ff <= tl_mem[slot_ff];
      st_rd_ff <= st_mem[slot_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clear_idx_ff <= '0;
         total_limit_ff <= 14'd8192;
         band_limit_ff <= 11'd1024;
         flow_mask_ff <= 10'd1023;
         for (int i = 0; i < BAND_COUNT; i++) begin
            bound_ff[i] <= '0;
            head_ff[i] <= '0;
            count_ff[i] <= '0;
         end
         total_ff <= '0;
         gvt_ff <= '0;
         write_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CsrTotalLimit: total_limit_ff <= csr_wdata[13:0];
               CsrBandLimit:  band_limit_ff <= csr_wdata[10:0];
               CsrHashMask:   flow_mask_ff <= csr_wdata[9:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_CLEAR: begin
               clear_idx_ff <= clear_idx_ff + 1'b1;
               if (clear_idx_ff == FW'(FLOW_ENTRIES - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_tvalid) begin
                  kind_ff <= req_tuser;
                  fi_ff <= fi_in;
                  len_ff <= req_tdata[47:32];
                  tag_ff <= req_tdata[63:48];
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_CALC;
            S_CALC: begin
               write_ff <= 1'b0;
               otag_ff <= '0;
               olen_ff <= '0;
               reo_ff <= 1'b0;
               inv_ff <= 1'b0;
               vt_ff <= '0;
               band_ff <= '0;
               if (!kind_ff) begin
                  if (32'(total_ff) >= 32'(total_limit_ff)) begin
                     status_ff <= StDropTotal;
                  end else begin
                     band_ff <= eb_c;
                     vt_ff <= vt_c;
                     inv_ff <= inv_c;
                     if (inv_c) begin
                        for (int i = 0; i < BAND_COUNT - 1; i++)
                           bound_ff[i] <= bound_ff[i] - cost_c;
                     end
                     if (count_ff[eb_c] >= lim_c) begin
                        status_ff <= StDropBand;
                     end else begin
                        status_ff <= StEnqueued;
                        bound_ff[eb_c] <= vt_c;
                        slot_ff <= {eb_c, DW'(head_ff[eb_c] + DW'(count_ff[eb_c]))};
                        write_ff <= 1'b1;
                        count_ff[eb_c] <= count_ff[eb_c] + 1'b1;
                        total_ff <= total_ff + 1'b1;
                     end
                  end
               end else if (total_ff == '0 || !found_c) begin
                  status_ff <= StEmpty;
               end else begin
                  status_ff <= StDequeued;
                  band_ff <= db_c;
                  slot_ff <= {db_c, head_ff[db_c]};
                  head_ff[db_c] <= head_ff[db_c] + 1'b1;
                  count_ff[db_c] <= count_ff[db_c] - 1'b1;
                  total_ff <= total_ff - 1'b1;
               end
               state_ff <= S_MEM;
            end
            S_MEM: begin
               write_ff <= 1'b0;
               state_ff <= S_WAIT;
            end
            // packet memory read data lands here for a dequeue
            S_WAIT: state_ff <= S_OUT;
            S_OUT: begin
               if (rsp_tready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
         // dequeue result capture, in the cycle after the packet memory read
         if (state_ff == S_WAIT && status_ff == StDequeued) begin
            otag_ff <= tl_rd_ff[31:16];
            olen_ff <= tl_rd_ff[15:0];
            vt_ff <= st_rd_ff;
            if (total_ff == '0) begin
               gvt_ff <= pop_end_c;
            end else if (later(st_rd_ff, gvt_ff)) begin
               gvt_ff <= st_rd_ff;
            end else begin
               reo_ff <= 1'b1;
            end
         end
      end
   end

   `SPS_ASSERT(a_one_busy, clock, reset, rsp_tvalid |-> !req_tready, "response with request open")
   `SPS_ASSERT(a_total_bound, clock, reset, 32'(total_ff) <= SLOTS, "total count overflow")
   `SPS_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "response lost")
   `SPS_ASSERT(a_status_range, clock, reset, rsp_tvalid |-> rsp_tuser <= 3'd4, "bad status")

endmodule
`default_nettype wire

@@ sim/sched_checker.sv @@
// watches the scheduler channels, predicts each response and compares it
`timescale 1ns / 1ps
`default_nettype none
module sched_checker #(
   parameter logic DEQUEUE_KIND = 1'b1
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   input  wire logic                                  req_tready,
   input  wire logic [sps_pkg::ReqDataWidth-1:0]      req_tdata,
   input  wire logic                                  req_tuser,
   input  wire logic                                  rsp_tvalid,
   input  wire logic                                  rsp_tready,
   input  wire logic [sps_pkg::RspDataWidth-1:0]      rsp_tdata,
   input  wire logic [2:0]                            rsp_tuser,
   input  wire logic                                  csr_we,
   input  wire logic [sps_pkg::CsrIndexWidth-1:0]     csr_index,
   input  wire logic [sps_pkg::CsrDataWidth-1:0]      csr_wdata,
   output int                                         mismatch_count,
   output int                                         responses_owed
);
   import sps_pkg::*;

   localparam int Bands = 8;
   localparam int Depth = 1024;
   localparam int Flows = 1024;

   typedef struct packed {
      status_type  status;
      logic [2:0]  band;
      logic [15:0] tag;
      logic [15:0] len;
      logic [63:0] start;
      logic        inv;
      logic        reo;
   } sched_result_type;

   sched_result_type owed_responses[$];

   logic [13:0] total_limit;
   logic [10:0] band_limit;
   logic [9:0]  flow_mask;
   logic        flow_seen [Flows];
   logic [63:0] flow_tail [Flows];
   logic [63:0] bound [Bands];
   logic [63:0] vtime;
   logic [63:0] slot_start [Bands][Depth];
   logic [15:0] slot_tag [Bands][Depth];
   logic [15:0] slot_len [Bands][Depth];
   logic [9:0]  head [Bands];
   logic [10:0] fill [Bands];
   logic [13:0] queued;

   function automatic logic is_after(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] d;
      d = b - a;
      return d[63];
   endfunction

   task automatic schedule_enqueue(input logic [31:0] hash, input logic [15:0] len,
                                   input logic [15:0] tag, output sched_result_type r);
      int fi;
      int b;
      int lim;
      logic [63:0] vt;
      logic [63:0] shortfall;
      logic placed;
      r = '0;
      r.status = StEnqueued;
      if (queued >= total_limit) begin
         r.status = StDropTotal;
         return;
      end
      fi = int'(hash[9:0] & flow_mask);
      if (!flow_seen[fi]) begin
         flow_seen[fi] = 1'b1;
         flow_tail[fi] = vtime;
      end
      vt = is_after(vtime, flow_tail[fi]) ? vtime : flow_tail[fi];
      flow_tail[fi] = vt + 64'(len);
      placed = 1'b0;
      b = Bands - 1;
      for (int i = 0; i < Bands - 1; i++) begin
         if (!placed && !is_after(bound[i], vt)) begin
            b = i;
            placed = 1'b1;
         end
      end
      if (!placed && is_after(bound[b], vt)) begin
         shortfall = bound[b] - vt;
         for (int i = 0; i < Bands - 1; i++) bound[i] -= shortfall;
         r.inv = 1'b1;
      end
      r.band = 3'(b);
      r.start = vt;
      lim = int'(band_limit);
      if (lim == 0 || lim > Depth) lim = Depth;
      if (int'(fill[b]) >= lim) begin
         r.status = StDropBand;
         return;
      end
      bound[b] = vt;
      slot_start[b][head[b] + 10'(fill[b])] = vt;
      slot_tag[b][head[b] + 10'(fill[b])] = tag;
      slot_len[b][head[b] + 10'(fill[b])] = len;
      fill[b]++;
      queued++;
   endtask

   task automatic schedule_dequeue(output sched_result_type r);
      int b;
      r = '0;
      b = -1;
      for (int i = Bands - 1; i >= 0; i--) if (b < 0 && fill[i] != 0) b = i;
      if (queued == 0 || b < 0) begin
         r.status = StEmpty;
         return;
      end
      r.status = StDequeued;
      r.band = 3'(b);
      r.start = slot_start[b][head[b]];
      r.tag = slot_tag[b][head[b]];
      r.len = slot_len[b][head[b]];
      head[b]++;
      fill[b]--;
      queued--;
      if (queued == 0) vtime = r.start + 64'(r.len);
      else if (is_after(r.start, vtime)) vtime = r.start;
      else r.reo = 1'b1;
   endtask

   always @(posedge clock) begin
      sched_result_type want;
      sched_result_type got;
      if (reset) begin
         total_limit = 14'd8192;
         band_limit = 11'd1024;
         flow_mask = 10'd1023;
         for (int i = 0; i < Flows; i++) flow_seen[i] = 1'b0;
         for (int i = 0; i < Bands; i++) begin
            bound[i] = '0;
            head[i] = '0;
            fill[i] = '0;
         end
         vtime = '0;
         queued = '0;
         owed_responses.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status = status_type'(rsp_tuser);
            got.band = rsp_tdata[2:0];
            got.tag = rsp_tdata[18:3];
            got.len = rsp_tdata[34:19];
            got.start = rsp_tdata[98:35];
            got.inv = rsp_tdata[99];
            got.reo = rsp_tdata[100];
            if (owed_responses.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response status %0d band %0d", got.status, got.band);
            end else begin
               want = owed_responses.pop_front();
               if (want != got) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("mismatch at %0t: exp st %0d b %0d tag %h len %h start %h",
                              $realtime, want.status, want.band, want.tag, want.len,
                              want.start, " inv %b reo %b", want.inv, want.reo);
                     $display("   got st %0d b %0d tag %h len %h start %h inv %b reo %b",
                              got.status, got.band, got.tag, got.len, got.start,
                              got.inv, got.reo);
                  end
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == DEQUEUE_KIND) schedule_dequeue(want);
            else schedule_enqueue(req_tdata[31:0], req_tdata[47:32], req_tdata[63:48], want);
            owed_responses.push_back(want);
         end
         if (csr_we) begin
            case (csr_index)
               CsrTotalLimit: total_limit = csr_wdata[13:0];
               CsrBandLimit:  band_limit = csr_wdata[10:0];
               CsrHashMask:   flow_mask = csr_wdata[9:0];
               default: ;
            endcase
         end
      end
      responses_owed = owed_responses.size();
   end
endmodule
`default_nettype wire

@@ sim/testbench.sv @@
// stimulus and verdict for the packet scheduler
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import sps_pkg::*;

   localparam logic KindEnqueue = 1'b0;
   localparam logic KindDequeue = 1'b1;
   localparam logic [CsrIndexWidth-1:0] CsrUnused = 2'd3;
   localparam int IdleLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ReqDataWidth-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0] csr_wdata = '0;
   int mismatch_count;
   int responses_owed;
   int idle_cycles = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_phase = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sp_pifo_stfq_packet_scheduler dut (.*);

   sched_checker #(.DEQUEUE_KIND(KindDequeue)) monitor (.*);

   // receiver: stretches of steady readiness alternate with random stalling
   always @(posedge clock) begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 64 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic send(input logic kind, input logic [31:0] hash, input logic [15:0] len,
                       input logic [15:0] tag);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {tag, len, hash};
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic drain_and_pause();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (responses_owed != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIndexWidth-1:0] idx, input int value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CsrDataWidth'(value);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_traffic(input int count, input int enq_weight, input logic narrow);
      logic [31:0] hash;
      logic [15:0] len;
      for (int n = 0; n < count; n++) begin
         hash = narrow ? 32'($urandom_range(0, 7)) : $urandom;
         if ($urandom_range(0, 7) == 0) hash[31:10] = 22'($urandom);
         case ($urandom_range(0, 9))
            0: len = 16'h0000;
            1: len = 16'hffff;
            2, 3: len = 16'($urandom);
            default: len = 16'($urandom_range(1, 1500));
         endcase
         if ($urandom_range(0, 99) < enq_weight) send(KindEnqueue, hash, len, 16'($urandom));
         else send(KindDequeue, $urandom, 16'($urandom), 16'($urandom));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // dequeue from an empty scheduler, field extremes, shared flow, inversion
      send(KindDequeue, 32'hffffffff, 16'hffff, 16'hffff);
      send(KindEnqueue, 32'h0000_0000, 16'h0000, 16'h0000);
      send(KindEnqueue, 32'hffff_ffff, 16'hffff, 16'hffff);
      send(KindEnqueue, 32'hffff_ffff, 16'hffff, 16'h1234);
      send(KindEnqueue, 32'h0000_0400, 16'd1250, 16'h5555);
      send(KindEnqueue, 32'h0000_0000, 16'd1250, 16'haaaa);
      send(KindEnqueue, 32'h0000_0011, 16'd64, 16'h0001);
      send(KindEnqueue, 32'h0000_0022, 16'd64, 16'h0002);
      for (int i = 0; i < 6; i++) send(KindDequeue, 32'h0, 16'h0, 16'h0);
      send(KindEnqueue, 32'h0000_03ff, 16'd100, 16'hbeef);
      send(KindDequeue, 32'h0, 16'h0, 16'h0);
      send(KindDequeue, 32'h0, 16'h0, 16'h0);
      drain_and_pause();

      // tight limits so both kinds of drop occur
      write_reg(CsrTotalLimit, 5);
      write_reg(CsrBandLimit, 1);
      write_reg(CsrHashMask, 3);
      random_traffic(150, 65, 1'b1);
      drain_and_pause();

      // nothing may be queued at all
      write_reg(CsrTotalLimit, 0);
      write_reg(CsrBandLimit, 0);
      write_reg(CsrUnused, 16383);
      random_traffic(40, 50, 1'b0);
      drain_and_pause();

      // every hash maps to one flow
      write_reg(CsrTotalLimit, 8192);
      write_reg(CsrHashMask, 0);
      random_traffic(200, 60, 1'b0);
      drain_and_pause();

      write_reg(CsrTotalLimit, 1);
      write_reg(CsrBandLimit, 1024);
      write_reg(CsrHashMask, 1023);
      random_traffic(60, 60, 1'b0);
      drain_and_pause();

      write_reg(CsrTotalLimit, 8192);
      write_reg(CsrBandLimit, 3);
      random_traffic(150, 70, 1'b1);
      drain_and_pause();

      write_reg(CsrBandLimit, 1024);
      random_traffic(120, 80, 1'b0);
      random_traffic(100, 25, 1'b0);
      drain_and_pause();

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire
